FILE: rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked at every rising clock edge outside reset.
`define TCW_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Overlapping implication, checked outside reset.
`define TCW_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

FILE: rtl/core/tcw_pkg.sv
package tcw_pkg;

  // Default geometry of the cell store.
  localparam int MAX_COLS_DEF = 128;
  localparam int MAX_ROWS_DEF = 32;

  // Field widths.
  localparam int OP_W       = 2;
  localparam int CHAR_W     = 8;
  localparam int POS_W      = 8;
  localparam int CELL_W     = 16;
  localparam int CFG_COLS_W = 8;
  localparam int CFG_ROWS_W = 6;
  localparam int IDX_W      = 4;
  localparam int COLOUR_W   = 4;
  localparam int OUT_COL_W  = 7;
  localparam int OUT_ROW_W  = 5;
  localparam int LIN_W      = 12;

  // Working row before scrolling: pos_y plus the folded quotient.
  localparam int ROW_W = POS_W + 1;

  // Port widths.
  localparam int S_TDATA_W   = 24;
  localparam int M_TDATA_W   = 48;
  localparam int M_PAD_W     = M_TDATA_W - (OUT_COL_W + OUT_ROW_W + LIN_W + 1 + 2 * CHAR_W);
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 8;

  // Register reset values.
  localparam int RESET_COLUMNS = 80;
  localparam int RESET_ROWS    = 25;

  // Register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_COLUMNS  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ROWS     = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_FG_INDEX = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_BG_INDEX = 2'd3;

  // Control characters.
  localparam logic [CHAR_W-1:0] CH_NUL = 8'h00;
  localparam logic [CHAR_W-1:0] CH_LF  = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR  = 8'h0D;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE  = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_SETCUR = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  // Ten-entry colour map; indexes of ten and above give black.
  function automatic logic [COLOUR_W-1:0] colour_of(input logic [IDX_W-1:0] idx);
    logic [COLOUR_W-1:0] c;
    case (idx)
      4'd0:    c = 4'h0;
      4'd1:    c = 4'hF;
      4'd2:    c = 4'h1;
      4'd3:    c = 4'h2;
      4'd4:    c = 4'h4;
      4'd5:    c = 4'h6;
      4'd6:    c = 4'hE;
      4'd7:    c = 4'h9;
      4'd8:    c = 4'hA;
      4'd9:    c = 4'hC;
      default: c = 4'h0;
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/core/tcw_ram.sv
module tcw_ram #(
  parameter int  WIDTH = tcw_pkg::CELL_W,
  parameter int  DEPTH = tcw_pkg::MAX_COLS_DEF * tcw_pkg::MAX_ROWS_DEF,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/tcw_div.sv
// Restoring divider, one quotient bit per cycle.
module tcw_div #(
  parameter int DVS_W = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [tcw_pkg::POS_W-1:0] dividend,
  input  logic [DVS_W-1:0]         divisor,
  output logic                     done,
  output logic [tcw_pkg::POS_W-1:0] quotient,
  output logic [DVS_W-1:0]         remainder
);

  localparam int DVD_W = tcw_pkg::POS_W;
  localparam int CNT_W = $clog2(DVD_W);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DVS_W-1:0] dvs;
  logic [DVS_W:0]   shifted;
  logic             fits;

  assign shifted = {remainder, quotient[DVD_W-1]};
  assign fits    = shifted >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !start && (cnt == CNT_W'(DVD_W - 1));
      if (start) begin
        busy      <= 1'b1;
        cnt       <= '0;
        dvs       <= divisor;
        quotient  <= dividend;
        remainder <= '0;
      end else if (busy) begin
        // shift in the next dividend bit, subtract when the divisor fits
        if (fits) begin
          remainder <= DVS_W'(shifted - {1'b0, dvs});
        end else begin
          remainder <= shifted[DVS_W-1:0];
        end
        quotient <= {quotient[DVD_W-2:0], fits};
        cnt      <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(DVD_W - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

FILE: rtl/core/text_console_writer.sv
// Text-mode console engine. The screen lives in an internal store of
// 16-bit cells (character low byte, attribute high byte).
// Input channel s_*: one item is one operation (write character, clear,
// set cursor, read cell). Output channel m_*: exactly one result item per
// input item, in order: cursor column/row, linear cursor position, scroll
// flag and, for a read, the cell contents.
// Configuration: cfg_wen/cfg_index/cfg_wdata, to be written only while idle
// by the user; the block itself does not enforce this.
// Set cursor runs a bit-serial divide of pos_x by the column count; clear
// and scroll sweep columns*rows store cells, one store cell per cycle,
// since the single write port sweeps the screen.
// A new item is taken once the previous one is finished; a result that
// waits in the output register does not block the next item, only the
// loading of its own result.
// Reset: after rst the store is cleared one cell per cycle, all
// MAX_COLS*MAX_ROWS cells (4096 by default), with s_tready low; the
// configuration port is taken during that time.
// Receiver stall: the finished result stays in the output register until
// m_tready takes it; the engine holds in S_OUT only when the next result
// is ready to load.
`include "assert_macros.svh"

module text_console_writer #(
  parameter int MAX_COLS = tcw_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = tcw_pkg::MAX_ROWS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // s_tdata: char_code[7:0], pos_x[15:8], pos_y[23:16]
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [tcw_pkg::S_TDATA_W-1:0]    s_tdata,
  // s_tuser: operation[1:0]
  input  logic [tcw_pkg::OP_W-1:0]         s_tuser,
  // m_tdata: cursor_col[6:0], cursor_row[11:7], cursor_linear[23:12],
  //          scrolled[24], cell_char[32:25], cell_attr[40:33], zero[47:41]
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [tcw_pkg::M_TDATA_W-1:0]    m_tdata,
  input  logic                             cfg_wen,
  input  logic [tcw_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [tcw_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int COL_W  = $clog2(MAX_COLS);
  localparam int CI_W   = COL_W + 1;
  localparam int NC_W   = $clog2(MAX_COLS + 1);
  localparam int NR_W   = $clog2(MAX_ROWS + 1);
  localparam int DEPTH  = MAX_COLS * MAX_ROWS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int ROW_W  = tcw_pkg::ROW_W;
  localparam int MUL_W  = ROW_W + NC_W;
  localparam int POS_W  = tcw_pkg::POS_W;
  localparam int CHAR_W = tcw_pkg::CHAR_W;
  localparam int CELL_W = tcw_pkg::CELL_W;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_EXEC   = 8'b0000_0010,
    S_DIV    = 8'b0000_0100,
    S_RDAT   = 8'b0000_1000,
    S_SETTLE = 8'b0001_0000,
    S_LIN    = 8'b0010_0000,
    S_SWEEP  = 8'b0100_0000,
    S_OUT    = 8'b1000_0000
  } state_t;

  state_t state;

  // configuration registers
  logic [tcw_pkg::CFG_COLS_W-1:0] columns;
  logic [tcw_pkg::CFG_ROWS_W-1:0] rows;
  logic [tcw_pkg::IDX_W-1:0]      fg_index;
  logic [tcw_pkg::IDX_W-1:0]      bg_index;

  // effective geometry
  logic [NC_W-1:0] nc;
  logic [NR_W-1:0] nr;

  // cursor
  logic [COL_W-1:0] cur_col;
  logic [ROW_W-1:0] cur_row;

  // latched item
  tcw_pkg::op_t     op;
  logic [CHAR_W-1:0] ch;
  logic [POS_W-1:0] px;
  logic [POS_W-1:0] py;

  // work registers
  logic [ADDR_W-1:0] prod;
  logic [ADDR_W-1:0] lin;
  logic [ADDR_W-1:0] off;
  logic [NR_W-1:0]   keep_rows;
  logic              scr;
  logic              rd_ok;
  logic [CELL_W-1:0] rd_cell;

  // sweep counters and write-back stage
  logic [ADDR_W-1:0] sw_addr;
  logic [NC_W-1:0]   sw_col;
  logic [NR_W-1:0]   sw_row;
  logic              sw_init;
  logic              sw_last;
  logic              sw_v1;
  logic [ADDR_W-1:0] sw_addr1;
  logic              sw_copy1;

  // shared multiplier
  logic [ROW_W-1:0] mul_a;
  logic [MUL_W-1:0] mul_p;

  // cell store ports
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [CELL_W-1:0] ram_rdata;

  // divider
  logic              div_start;
  logic              div_done;
  logic [POS_W-1:0]  div_quo;
  logic [NC_W-1:0]   div_rem;

  // misc combinational
  logic [CI_W-1:0]   col_inc;
  logic              col_wrap;
  logic              ch_plain;
  logic              exec_wr;
  logic              row_hi;
  logic [ROW_W-1:0]  scroll_k;
  logic              in_range;
  logic [CHAR_W-1:0] attr;
  logic [COL_W+tcw_pkg::OUT_COL_W-1:0] col_ext;
  logic [ADDR_W+tcw_pkg::LIN_W-1:0]    lin_ext;

  // ------------------------------------------------------------------
  // Configuration port
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      columns  <= tcw_pkg::CFG_COLS_W'(tcw_pkg::RESET_COLUMNS);
      rows     <= tcw_pkg::CFG_ROWS_W'(tcw_pkg::RESET_ROWS);
      fg_index <= '0;
      bg_index <= '0;
    end else if (cfg_wen) begin
      case (cfg_index)
        tcw_pkg::REG_COLUMNS:  columns  <= cfg_wdata;
        tcw_pkg::REG_ROWS:     rows     <= cfg_wdata[tcw_pkg::CFG_ROWS_W-1:0];
        tcw_pkg::REG_FG_INDEX: fg_index <= cfg_wdata[tcw_pkg::IDX_W-1:0];
        tcw_pkg::REG_BG_INDEX: bg_index <= cfg_wdata[tcw_pkg::IDX_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the geometry to what the store holds; a zero count gives one.
  always_comb begin
    if (columns == '0) begin
      nc = NC_W'(1);
    end else if (32'(columns) > 32'(MAX_COLS)) begin
      nc = NC_W'(MAX_COLS);
    end else begin
      nc = NC_W'(columns);
    end
    if (rows == '0) begin
      nr = NR_W'(1);
    end else if (32'(rows) > 32'(MAX_ROWS)) begin
      nr = NR_W'(MAX_ROWS);
    end else begin
      nr = NR_W'(rows);
    end
  end

  // ------------------------------------------------------------------
  // Datapath helpers
  // ------------------------------------------------------------------
  assign attr     = {tcw_pkg::colour_of(bg_index), tcw_pkg::colour_of(fg_index)};
  assign ch_plain = (ch != tcw_pkg::CH_NUL) && (ch != tcw_pkg::CH_LF) &&
                    (ch != tcw_pkg::CH_CR);
  assign exec_wr  = (state == S_EXEC) && (op == tcw_pkg::OP_WRITE) && ch_plain;
  assign col_inc  = {1'b0, cur_col} + CI_W'(1);
  assign col_wrap = 32'(col_inc) >= 32'(nc);
  assign row_hi   = 32'(cur_row) >= 32'(nr);
  // rows to drop so that the cursor lands on the bottom row
  assign scroll_k = cur_row - ROW_W'(nr) + ROW_W'(1);
  assign in_range = (32'(px) < 32'(nc)) && (32'(py) < 32'(nr));

  // One multiplier by the column count, shared by address, scroll offset
  // and linear cursor position.
  always_comb begin
    case (state)
      S_IDLE:   mul_a = (s_tuser == tcw_pkg::OP_READ) ?
                        ROW_W'(s_tdata[3*POS_W-1:2*POS_W]) : cur_row;
      S_SETTLE: mul_a = row_hi ? scroll_k : cur_row;
      default:  mul_a = cur_row;
    endcase
  end
  assign mul_p = MUL_W'(mul_a) * MUL_W'(nc);

  // Store access: the sweep write-back stage owns the write port when busy.
  assign ram_we    = sw_v1 | exec_wr;
  assign ram_waddr = sw_v1 ? sw_addr1 : prod + ADDR_W'(cur_col);
  assign ram_wdata = sw_v1 ? (sw_copy1 ? ram_rdata : '0) : {attr, ch};
  assign ram_raddr = (state == S_SWEEP) ? sw_addr + off : prod + ADDR_W'(px);

  assign sw_last = sw_init ? (sw_addr == ADDR_W'(DEPTH - 1)) :
                   ((sw_row == nr - NR_W'(1)) && (sw_col == nc - NC_W'(1)));

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  tcw_div #(
    .DVS_W (NC_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (px),
    .divisor   (nc),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign s_tready = (state == S_IDLE);

  assign col_ext = (COL_W + tcw_pkg::OUT_COL_W)'(cur_col);
  assign lin_ext = (ADDR_W + tcw_pkg::LIN_W)'(lin);

  // ------------------------------------------------------------------
  // Sequencer
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_SWEEP;
      sw_init   <= 1'b1;
      sw_addr   <= '0;
      sw_col    <= '0;
      sw_row    <= '0;
      sw_v1     <= 1'b0;
      keep_rows <= '0;
      off       <= '0;
      cur_col   <= '0;
      cur_row   <= '0;
      div_start <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      // write back in the cycle after each sweep read
      sw_v1     <= (state == S_SWEEP);
      div_start <= (state == S_EXEC) && (op == tcw_pkg::OP_SETCUR);
      if ((state == S_OUT) && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            op      <= tcw_pkg::op_t'(s_tuser);
            ch      <= s_tdata[CHAR_W-1:0];
            px      <= s_tdata[CHAR_W+POS_W-1:CHAR_W];
            py      <= s_tdata[CHAR_W+2*POS_W-1:CHAR_W+POS_W];
            prod    <= mul_p[ADDR_W-1:0];
            scr     <= 1'b0;
            rd_cell <= '0;
            state   <= S_EXEC;
          end
        end
        S_EXEC: begin
          case (op)
            tcw_pkg::OP_WRITE: begin
              if (ch == tcw_pkg::CH_LF) begin
                cur_col <= '0;
                cur_row <= cur_row + ROW_W'(1);
                state   <= S_SETTLE;
              end else if (ch == tcw_pkg::CH_CR) begin
                cur_col <= '0;
                state   <= S_SETTLE;
              end else if (ch == tcw_pkg::CH_NUL) begin
                state <= S_LIN;
              end else begin
                // cell is written by the store port this cycle; advance
                if (col_wrap) begin
                  cur_col <= '0;
                  cur_row <= cur_row + ROW_W'(1);
                end else begin
                  cur_col <= col_inc[COL_W-1:0];
                end
                state <= S_SETTLE;
              end
            end
            tcw_pkg::OP_CLEAR: begin
              cur_col   <= '0;
              cur_row   <= '0;
              sw_addr   <= '0;
              sw_col    <= '0;
              sw_row    <= '0;
              keep_rows <= '0;
              off       <= '0;
              state     <= S_SWEEP;
            end
            tcw_pkg::OP_SETCUR: begin
              state <= S_DIV;
            end
            tcw_pkg::OP_READ: begin
              rd_ok <= in_range;
              state <= S_RDAT;
            end
            default: state <= S_LIN;
          endcase
        end
        S_DIV: begin
          if (div_done) begin
            // column folds into extra rows
            cur_col <= div_rem[COL_W-1:0];
            cur_row <= ROW_W'(py) + ROW_W'(div_quo);
            state   <= S_SETTLE;
          end
        end
        S_RDAT: begin
          if (rd_ok) begin
            rd_cell <= ram_rdata;
          end
          state <= S_LIN;
        end
        S_SETTLE: begin
          if (row_hi) begin
            // scroll: copy the kept rows up, blank the rest of the screen
            if (32'(scroll_k) >= 32'(nr)) begin
              keep_rows <= '0;
            end else begin
              keep_rows <= nr - scroll_k[NR_W-1:0];
            end
            off     <= mul_p[ADDR_W-1:0];
            cur_row <= ROW_W'(nr) - ROW_W'(1);
            scr     <= 1'b1;
            sw_addr <= '0;
            sw_col  <= '0;
            sw_row  <= '0;
            state   <= S_SWEEP;
          end else begin
            lin   <= mul_p[ADDR_W-1:0] + ADDR_W'(cur_col);
            state <= S_OUT;
          end
        end
        S_LIN: begin
          lin   <= mul_p[ADDR_W-1:0] + ADDR_W'(cur_col);
          state <= S_OUT;
        end
        S_SWEEP: begin
          // issue the source read now, write back in the next cycle
          sw_addr1 <= sw_addr;
          sw_copy1 <= sw_row < keep_rows;
          sw_addr  <= sw_addr + ADDR_W'(1);
          if (sw_col == nc - NC_W'(1)) begin
            sw_col <= '0;
            sw_row <= sw_row + NR_W'(1);
          end else begin
            sw_col <= sw_col + NC_W'(1);
          end
          if (sw_last) begin
            sw_init <= 1'b0;
            state   <= sw_init ? S_IDLE : S_SETTLE;
          end
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {{tcw_pkg::M_PAD_W{1'b0}}, rd_cell, scr,
                         lin_ext[tcw_pkg::LIN_W-1:0],
                         cur_row[tcw_pkg::OUT_ROW_W-1:0],
                         col_ext[tcw_pkg::OUT_COL_W-1:0]};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // ------------------------------------------------------------------
  // Assertions
  // ------------------------------------------------------------------
  `TCW_ASSERT(a_wport_free, clk, rst, !(sw_v1 && exec_wr), "store write port collision")
  `TCW_ASSERT_IMP(a_div_owner, clk, rst, div_done, state == S_DIV, "divider done outside wait")
  `TCW_ASSERT_IMP(a_scroll_row, clk, rst, (state == S_OUT) && scr,
                  cur_row == ROW_W'(nr) - ROW_W'(1), "scrolled cursor not on bottom row")
  `TCW_ASSERT_IMP(a_init_block, clk, rst, sw_init, !s_tready, "item taken during store clear")

endmodule
